// File: rtl/core/prf_pkg.sv
// Package for the Pollard rho factor unit: status codes and controller/datapath command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package prf_pkg;

  localparam logic [1:0] ST_FOUND = 2'd0;
  localparam logic [1:0] ST_FAIL  = 2'd1;
  localparam logic [1:0] ST_SMALL = 2'd2;

  localparam int unsigned LOW_BOUND   = 100;
  localparam int unsigned START_VALUE = 2;

  // Datapath operations requested by the controller.
  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,  // take N, set x = y = 2
    OP_SQX   = 3'd1,  // x = x*x + 1 mod N
    OP_SQY   = 3'd2,  // y = y*y + 1 mod N
    OP_GINIT = 3'd3,  // a = N, b = |x - y|
    OP_GSTEP = 3'd4   // not acted on by the datapath; the gcd steps run on their own after OP_GINIT
  } prf_op_t;

  typedef struct packed {
    logic    start;
    prf_op_t op;
  } prf_cmd_t;

  typedef struct packed {
    logic busy;      // a multi-cycle operation is running
    logic too_small; // N below the lower bound
    logic gcd_done;  // gcd finished
    logic gcd_one;   // result equals one
    logic gcd_n;     // result equals N
  } prf_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/prf_datapath.sv
// Datapath of the Pollard rho factor unit: shift-and-add modular squaring and binary gcd.
// Depends on prf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prf_datapath import prf_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire prf_cmd_t         cmd,
  input  wire logic [WIDTH-1:0] n_in,
  output prf_sts_t              sts,
  output logic [WIDTH-1:0]      gcd_out
);

  localparam int CW = $clog2(WIDTH + 1);
  localparam int IW = $clog2(WIDTH);

  logic [WIDTH-1:0] n_r, x_r, y_r, a_r, b_r, acc_r, src_r;
  logic [CW-1:0]    cnt_r, sh_r;
  logic             mbusy_r, tgt_y_r, inc_r, gbusy_r;

  // One step of the shift-and-add product: acc = 2*acc (+ src) mod N.
  logic [WIDTH:0]   dbl, dbl_m, ad, ad_m;
  logic [WIDTH-1:0] dblr, step_v;
  logic [WIDTH:0]   inc_s;
  logic [WIDTH-1:0] inc_v;
  logic [CW-1:0]    cnt_m1;
  logic [IW-1:0]    bidx;

  always_comb begin
    dbl    = {acc_r, 1'b0};
    dbl_m  = dbl - {1'b0, n_r};
    dblr   = dbl_m[WIDTH] ? dbl[WIDTH-1:0] : dbl_m[WIDTH-1:0];
    ad     = {1'b0, dblr} + {1'b0, src_r};
    ad_m   = ad - {1'b0, n_r};
    cnt_m1 = cnt_r - CW'(1);
    bidx   = cnt_m1[IW-1:0];
    if (src_r[bidx]) begin
      step_v = ad_m[WIDTH] ? ad[WIDTH-1:0] : ad_m[WIDTH-1:0];
    end else begin
      step_v = dblr;
    end
    inc_s = {1'b0, acc_r} + {{WIDTH{1'b0}}, 1'b1};
    inc_v = (inc_s == {1'b0, n_r}) ? '0 : inc_s[WIDTH-1:0];
  end

  // Binary gcd step on (a, b) with common shift count.
  logic [WIDTH-1:0] gdiff;
  assign gdiff = (a_r > b_r) ? a_r - b_r : b_r - a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
      gbusy_r <= 1'b0;
      inc_r   <= 1'b0;
    end else begin
      if (cmd.start) begin
        case (cmd.op)
          OP_LOAD: begin
            n_r <= n_in;
            x_r <= WIDTH'(START_VALUE);
            y_r <= WIDTH'(START_VALUE);
          end
          OP_SQX, OP_SQY: begin
            src_r   <= (cmd.op == OP_SQY) ? y_r : x_r;
            tgt_y_r <= (cmd.op == OP_SQY);
            acc_r   <= '0;
            cnt_r   <= CW'(WIDTH);
            mbusy_r <= 1'b1;
          end
          OP_GINIT: begin
            a_r     <= n_r;
            b_r     <= (x_r > y_r) ? x_r - y_r : y_r - x_r;
            sh_r    <= '0;
            gbusy_r <= 1'b1;
          end
          default: begin
          end
        endcase
      end
      if (mbusy_r) begin
        if (inc_r) begin
          inc_r   <= 1'b0;
          mbusy_r <= 1'b0;
          if (tgt_y_r) y_r <= inc_v;
          else x_r <= inc_v;
        end else begin
          acc_r <= step_v;
          cnt_r <= cnt_m1;
          if (cnt_r == CW'(1)) inc_r <= 1'b1;
        end
      end
      if (gbusy_r) begin
        if (b_r == '0) begin
          a_r     <= a_r << sh_r;
          gbusy_r <= 1'b0;
        end else if (a_r == '0) begin
          a_r <= b_r;
          b_r <= '0;
        end else if (!a_r[0] && !b_r[0]) begin
          a_r  <= a_r >> 1;
          b_r  <= b_r >> 1;
          sh_r <= sh_r + CW'(1);
        end else if (!a_r[0]) begin
          a_r <= a_r >> 1;
        end else if (!b_r[0]) begin
          b_r <= b_r >> 1;
        end else if (a_r > b_r) begin
          a_r <= gdiff;
        end else begin
          b_r <= gdiff;
        end
      end
    end
  end

  assign sts.busy      = mbusy_r | gbusy_r;
  assign sts.too_small = (n_r < WIDTH'(LOW_BOUND));
  assign sts.gcd_done  = !gbusy_r;
  assign sts.gcd_one   = (a_r == WIDTH'(1));
  assign sts.gcd_n     = (a_r == n_r);
  assign gcd_out       = a_r;

endmodule
`default_nettype wire

// File: rtl/core/prf_ctrl.sv
// Controller of the Pollard rho factor unit: sequences rounds and drives the handshakes.
// Depends on prf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module prf_ctrl import prf_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire prf_sts_t sts,
  output prf_cmd_t      cmd,
  output logic [1:0]    res_status,
  output logic          res_take
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CHECK = 8'b0000_0010,
    S_SQX   = 8'b0000_0100,
    S_SQY1  = 8'b0000_1000,
    S_SQY2  = 8'b0001_0000,
    S_GCD   = 8'b0010_0000,
    S_WAIT  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   launched_r, launched_nxt;
  logic [1:0] status_r, status_nxt;

  always_comb begin
    state_nxt    = state_r;
    launched_nxt = launched_r;
    status_nxt   = status_r;
    cmd          = '{start: 1'b0, op: OP_LOAD};
    res_take     = 1'b0;
    in_ready     = (state_r == S_IDLE);
    out_valid    = (state_r == S_OUT);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = '{start: 1'b1, op: OP_LOAD};
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        launched_nxt = 1'b0;
        if (sts.too_small) begin
          status_nxt = ST_SMALL;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_SQX;
        end
      end
      S_SQX, S_SQY1, S_SQY2, S_GCD: begin
        if (!launched_r) begin
          cmd.start    = 1'b1;
          cmd.op       = (state_r == S_SQX)  ? OP_SQX :
                         (state_r == S_GCD)  ? OP_GINIT : OP_SQY;
          launched_nxt = 1'b1;
        end else if (!sts.busy) begin
          launched_nxt = 1'b0;
          case (state_r)
            S_SQX:   state_nxt = S_SQY1;
            S_SQY1:  state_nxt = S_SQY2;
            S_SQY2:  state_nxt = S_GCD;
            default: state_nxt = S_WAIT;
          endcase
        end
      end
      S_WAIT: begin
        if (!sts.gcd_one) begin
          status_nxt = sts.gcd_n ? ST_FAIL : ST_FOUND;
          state_nxt  = S_OUT;
        end else begin
          state_nxt = S_SQX;
        end
      end
      S_OUT: begin
        res_take = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      launched_r <= 1'b0;
      status_r   <= ST_SMALL;
    end else begin
      state_r    <= state_nxt;
      launched_r <= launched_nxt;
      status_r   <= status_nxt;
    end
  end

  assign res_status = status_r;

endmodule
`default_nettype wire

// File: rtl/core/pollard_rho_factor.sv
// Top level of the Pollard rho factor unit: joins controller and datapath.
// Depends on prf_pkg, prf_ctrl and prf_datapath.
//
// Usage: the input channel (in_valid, in_ready, in_n_value) takes one candidate N
// per transfer; only the low WIDTH bits are used. The result channel (out_valid,
// out_ready, out_status, out_factor) returns one result per candidate.
// Status 0 means a factor was found, 1 means the gcd reached N (primes end so),
// 2 means N was below 100; the factor is zero unless status is 0.
// One item is worked on at a time. Each round performs three modular squarings
// on a shift-and-add unit, then a binary gcd, and the item takes about sqrt(p)
// rounds for smallest factor p. Candidates below 100 skip the rounds: the
// controller goes from S_CHECK straight to S_OUT after the input transfer.
// Reset (rst_n low, synchronous) returns the controller to idle and drops any
// item in flight. When the receiver stalls, the result is held on the output
// ports and no new candidate is taken until the result transfer completes.
`timescale 1ns / 1ps
`default_nettype none
module pollard_rho_factor import prf_pkg::*; #(
  parameter int WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [63:0] in_n_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       out_status,
  output logic [63:0]      out_factor
);

  prf_cmd_t         cmd;
  prf_sts_t         sts;
  logic [WIDTH-1:0] gcd_val;
  logic [1:0]       res_status;
  logic             res_take;

  prf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd),
    .res_status (res_status),
    .res_take   (res_take)
  );

  prf_datapath #(.WIDTH(WIDTH)) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .n_in    (in_n_value[WIDTH-1:0]),
    .sts     (sts),
    .gcd_out (gcd_val)
  );

  // The factor is only meaningful for a found status.
  assign out_status = res_status;
  assign out_factor = (res_take && res_status == ST_FOUND) ? 64'(gcd_val) : 64'd0;

  // No new candidate is taken while a result is on offer.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n) !(in_ready && out_valid))
    else $error("input and output offered together");

  // A found factor is never one or zero.
  a_fact: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FOUND) |-> (out_factor != 64'd1 && out_factor != 64'd0))
    else $error("trivial factor reported");

  // A stalled result holds its status.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)))
    else $error("result changed under stall");

endmodule
`default_nettype wire

// File: dv/tb_pollard_rho_factor.sv
// Testbench for the Pollard rho factor unit: directed table then random candidates, checked against
// typed-in answers or a behavioural rho predictor. Depends on prf_pkg and pollard_rho_factor.
`timescale 1ns / 1ps
module tb_pollard_rho_factor;
  import prf_pkg::*;

  localparam int          N_RANDOM    = 100;
  localparam int          CALM_TAIL   = 15;       // final transfers run with no idling
  localparam longint      CYCLE_LIMIT = 20000000;
  localparam int          DRAIN_WAIT  = 40;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] factor;
  } rho_answer_t;

  // One directed row: the candidate, whether the answer is typed in, and that answer.
  typedef struct {
    logic [63:0] n;
    bit          fixed;
    logic [1:0]  status;
    logic [63:0] factor;
  } rho_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_n_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_status;
  logic [63:0] out_factor;

  rho_answer_t pending_answers[$];
  int          mismatches = 0;
  bit          stimulus_done = 1'b0;
  bit          calm = 1'b0;
  longint      cycle_count = 0;

  // The clock toggles every half period of 1 ns.
  always #1 clk = ~clk;

  pollard_rho_factor #(.WIDTH(64)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_n_value(in_n_value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_status(out_status),
    .out_factor(out_factor)
  );

  // One step of the map v -> v*v + 1 mod n, done with a double-width product.
  function automatic logic [63:0] rho_next(logic [63:0] v, logic [63:0] n);
    logic [127:0] sq;
    logic [127:0] wide_n;
    wide_n = {64'd0, n};
    sq = ({64'd0, v} * {64'd0, v}) % wide_n;
    sq = (sq + 128'd1) % wide_n;
    return sq[63:0];
  endfunction

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] t;
    while (b != 64'd0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // Floyd walk: the tortoise steps once and the hare twice per round until the gcd
  // of their distance with N is no longer one. A prime N ends on the gcd reaching N.
  function automatic rho_answer_t factor_candidate(logic [63:0] n);
    rho_answer_t ans;
    logic [63:0] x;
    logic [63:0] y;
    logic [63:0] d;
    logic [63:0] diff;
    if (n < 64'(LOW_BOUND)) begin
      ans.status = ST_SMALL;
      ans.factor = '0;
      return ans;
    end
    x = 64'(START_VALUE);
    y = 64'(START_VALUE);
    do begin
      x = rho_next(x, n);
      y = rho_next(rho_next(y, n), n);
      diff = (x > y) ? x - y : y - x;
      d = gcd64(n, diff);
    end while (d == 64'd1);
    if (d == n) begin
      ans.status = ST_FAIL;
      ans.factor = '0;
    end else begin
      ans.status = ST_FOUND;
      ans.factor = d;
    end
    return ans;
  endfunction

  // Candidates are built to keep the walk short: plain candidates stay at or below 3000
  // and products have a smallest prime factor of at most 1000, so a run takes only a few dozen rounds.
  function automatic logic [63:0] random_candidate();
    int unsigned pick;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] r;
    pick = $urandom_range(99, 0);
    r = {$urandom(), $urandom()};
    if (pick < 10) begin
      return 64'($urandom_range(99, 0));
    end else if (pick < 22) begin
      return 64'($urandom_range(3000, 100));
    end else begin
      p = 64'($urandom_range(1000, 2));
      q = r % (64'hFFFF_FFFF_FFFF_FFFF / p);
      if (q < 64'd2) begin
        q = 64'd2;
      end
      return p * q;
    end
  endfunction

  // Sender idling: before about one transfer in three, in_valid drops for a random burst; none in the calm tail.
  task automatic send_candidate(logic [63:0] n, bit has_fixed, rho_answer_t fixed_ans);
    int gap;
    if (!calm && $urandom_range(2, 0) == 0) begin
      gap = $urandom_range(18, 1);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_n_value <= n;
    do @(posedge clk); while (!in_ready);
    // The transfer took place at this edge, so the expectation is recorded now.
    pending_answers.push_back(has_fixed ? fixed_ans : factor_candidate(n));
    @(negedge clk);
  endtask

  // Receiver idling runs independently in bursts, and stops in the calm tail.
  initial begin
    int burst;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(3, 0) == 0) begin
        burst = $urandom_range(18, 1);
        out_ready <= 1'b0;
        repeat (burst) @(negedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(20, 1)) @(negedge clk);
    end
  end

  // Each result transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    rho_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected result: status=%0d factor=%0d", out_status, out_factor);
        end
      end else begin
        want = pending_answers.pop_front();
        if (want.status !== out_status || want.factor !== out_factor) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected status=%0d factor=%0d, got status=%0d factor=%0d",
                     want.status, want.factor, out_status, out_factor);
          end
        end
      end
    end
  end

  // Watchdog over the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    rho_row_t    rows[$];
    rho_answer_t fixed_ans;

    // Directed rows: small candidates and known primes have answers that can be
    // typed in; the rest go through the predictor.
    rows.push_back('{64'd0,                  1'b1, ST_SMALL, 64'd0});
    rows.push_back('{64'd1,                  1'b1, ST_SMALL, 64'd0});
    rows.push_back('{64'd2,                  1'b1, ST_SMALL, 64'd0});
    rows.push_back('{64'd99,                 1'b1, ST_SMALL, 64'd0});
    rows.push_back('{64'd100,                1'b0, ST_FOUND, 64'd0});
    rows.push_back('{64'd101,                1'b1, ST_FAIL,  64'd0});
    rows.push_back('{64'd997,                1'b1, ST_FAIL,  64'd0});
    rows.push_back('{64'd9973,               1'b1, ST_FAIL,  64'd0});
    rows.push_back('{64'd10403,              1'b0, ST_FOUND, 64'd0});
    rows.push_back('{64'd121,                1'b0, ST_FOUND, 64'd0});
    rows.push_back('{64'd8051,               1'b0, ST_FOUND, 64'd0});
    rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_FOUND, 64'd0});
    rows.push_back('{64'h8000_0000_0000_0000, 1'b0, ST_FOUND, 64'd0});
    rows.push_back('{64'hFFFF_FFFF_FFFF_FFFE, 1'b0, ST_FOUND, 64'd0});
    rows.push_back('{64'hAAAA_AAAA_AAAA_AAAB, 1'b0, ST_FOUND, 64'd0});
    rows.push_back('{64'h5555_5555_5555_5555, 1'b0, ST_FOUND, 64'd0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      fixed_ans.status = rows[i].status;
      fixed_ans.factor = rows[i].factor;
      send_candidate(rows[i].n, rows[i].fixed, fixed_ans);
    end

    for (int k = 0; k < N_RANDOM; k++) begin
      if (k >= N_RANDOM - CALM_TAIL) begin
        calm = 1'b1;
      end
      send_candidate(random_candidate(), 1'b0, fixed_ans);
    end
    in_valid <= 1'b0;
    stimulus_done = 1'b1;

    wait (pending_answers.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/prf_pkg.sv
rtl/core/prf_datapath.sv
rtl/core/prf_ctrl.sv
rtl/core/pollard_rho_factor.sv
dv/tb_pollard_rho_factor.sv
